// ===== hdl/sead_pkg.sv =====
package sead_pkg;

    localparam int DEFAULT_MAX_ITEMS = 64;
    localparam int VALUE_W           = 32;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } sead_state_t;

    typedef struct packed {
        logic insert;
        logic shift_dn;
        logic shift_up;
    } sead_op_t;

    typedef struct packed {
        logic               valid;
        logic               gt;
        logic [VALUE_W-1:0] value;
    } sead_link_t;

endpackage

// ===== hdl/sead_cell.sv =====
module sead_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sead_pkg::sead_op_t                  op,
    input  logic [sead_pkg::VALUE_W-1:0]        in_value,
    input  sead_pkg::sead_link_t                below,
    input  sead_pkg::sead_link_t                above,
    output sead_pkg::sead_link_t                link
);

    logic [sead_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                         valid_reg, valid_next;
    logic                         gt;

    assign gt = !valid_reg || ($signed(in_value) < $signed(value_reg));

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (op.insert) begin
            if (gt) begin
                if (below.gt) begin
                    value_next = below.value;
                    valid_next = below.valid;
                end else begin
                    value_next = in_value;
                    valid_next = 1'b1;
                end
            end
        end else if (op.shift_dn) begin
            value_next = above.value;
            valid_next = above.valid;
        end else if (op.shift_up) begin
            value_next = below.value;
            valid_next = below.valid;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

endmodule

// ===== hdl/sead_chain.sv =====
module sead_chain #(
    parameter int MAX_ITEMS = sead_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sead_pkg::sead_op_t              op,
    input  logic [sead_pkg::VALUE_W-1:0]    in_value,
    output sead_pkg::sead_link_t            bottom,
    output sead_pkg::sead_link_t            top
);

    sead_pkg::sead_link_t links [MAX_ITEMS];

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
            sead_pkg::sead_link_t below_l, above_l;
            if (i == 0) begin : g_lo
                assign below_l = '0;
            end else begin : g_mid_lo
                assign below_l = links[i-1];
            end
            if (i == MAX_ITEMS - 1) begin : g_hi
                assign above_l = '0;
            end else begin : g_mid_hi
                assign above_l = links[i+1];
            end
            sead_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .op       (op),
                .in_value (in_value),
                .below    (below_l),
                .above    (above_l),
                .link     (links[i])
            );
        end
    endgenerate

    assign bottom = links[0];
    assign top    = links[MAX_ITEMS-1];

endmodule

// ===== hdl/sort_engine_asc_desc_unit.sv =====
// Streaming sorter for signed 32-bit values, built as a row of insertion cells.
// Input channel s_*: one value per transaction in s_tdata, s_tlast closes the set.
// While collecting, s_tready is high and one value is taken every cycle; each
// value drops into its ascending place in the cell row in the cycle it arrives.
// Values beyond MAX_ITEMS are dropped and flag overflow for that set.
// After the closing transaction the block stops accepting and emits the set on
// m_*: sorted value in m_tdata, m_tlast on the final result, overflow in m_tuser.
// Ascending order pops from the bottom cell: first result in the cycle after the
// closing transaction, then one result per cycle while m_tready is high.
// Descending order pops from the top cell: the row first shifts up until the top
// cell holds a value, then one result per cycle while m_tready is high.
// A stalled receiver holds the row and the current result unchanged.
// cfg_* writes the descending bit (cfg_data bit 0); cfg_ready is always high and
// the bit is used when the set is emitted.
// Reset (aresetn low, synchronous) empties all cells, clears the count,
// the overflow flag and the descending bit, and returns to collecting.
module sort_engine_asc_desc_unit #(
    parameter int MAX_ITEMS = sead_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser,   // [0] overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    sead_pkg::sead_state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic                  desc_reg;
    sead_pkg::sead_op_t    op;
    sead_pkg::sead_link_t  bottom, top;
    logic                  s_xfer, m_xfer, room;

    sead_chain #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .in_value (s_tdata),
        .bottom   (bottom),
        .top      (top)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == sead_pkg::ST_COLLECT);
    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = m_tvalid && m_tready;
    assign room      = (count_reg < CNT_W'(MAX_ITEMS));

    assign m_tdata = desc_reg ? top.value : bottom.value;
    assign m_tlast = (count_reg == CNT_W'(1));
    assign m_tuser = ovf_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        op         = '0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            sead_pkg::ST_COLLECT: begin
                if (s_xfer) begin
                    if (room) begin
                        op.insert  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = sead_pkg::ST_EMIT;
                    end
                end
            end
            sead_pkg::ST_EMIT: begin
                m_tvalid = desc_reg ? top.valid : bottom.valid;
                if (desc_reg && !top.valid) begin
                    op.shift_up = 1'b1;
                end else if (m_xfer) begin
                    op.shift_dn = !desc_reg;
                    op.shift_up = desc_reg;
                    count_next  = count_reg - CNT_W'(1);
                    if (m_tlast) begin
                        ovf_next   = 1'b0;
                        state_next = sead_pkg::ST_COLLECT;
                    end
                end
            end
            default: begin
                state_next = sead_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sead_pkg::ST_COLLECT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            desc_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_valid && cfg_ready) begin
                desc_reg <= cfg_data;
            end
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while results pending");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sead_pkg::ST_EMIT) |-> (count_reg != '0))
        else $error("emitting with empty set");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |=> (s_tready && count_reg == '0 && !ovf_reg && !bottom.valid))
        else $error("set not cleared after final result");

endmodule
